>>> src/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside the disable condition.
`define ASSERT_ALWAYS(lbl, clk, dis, cond) \
    lbl: assert property (@(posedge clk) disable iff (dis) (cond)) \
        else $error("assertion failed: invariant");

// Implication in the same cycle.
`define ASSERT_IMPL(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Implication in the next cycle.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> src/rmn_pkg.sv
// Package with the types, constants and the median network of the filter.
package rmn_pkg;

    localparam int PIX_W    = 8;
    localparam int DIM_W    = 11;
    localparam int TAPS     = 9;
    localparam int MID_RANK = 4;

    // Register select, taken from address bit 2.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [DIM_W-1:0] t_dim;

    typedef struct packed {
        t_dim rows;
        t_dim cols;
    } t_dims;

    // The nine most recent pixels, newest in tap 0, and the end-of-frame mark.
    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] taps;
        logic                       last;
    } t_taps;

    // Nineteen compare-exchange steps; the true median ends up in rank four.
    function automatic t_pix median9(input logic [TAPS-1:0][PIX_W-1:0] v);
        t_pix t [TAPS];
        t_pix s;
        for (int k = 0; k < TAPS; k++) begin
            t[k] = v[k];
        end
        if (t[1] > t[2]) begin s = t[1]; t[1] = t[2]; t[2] = s; end
        if (t[4] > t[5]) begin s = t[4]; t[4] = t[5]; t[5] = s; end
        if (t[7] > t[8]) begin s = t[7]; t[7] = t[8]; t[8] = s; end
        if (t[0] > t[1]) begin s = t[0]; t[0] = t[1]; t[1] = s; end
        if (t[3] > t[4]) begin s = t[3]; t[3] = t[4]; t[4] = s; end
        if (t[6] > t[7]) begin s = t[6]; t[6] = t[7]; t[7] = s; end
        if (t[1] > t[2]) begin s = t[1]; t[1] = t[2]; t[2] = s; end
        if (t[4] > t[5]) begin s = t[4]; t[4] = t[5]; t[5] = s; end
        if (t[7] > t[8]) begin s = t[7]; t[7] = t[8]; t[8] = s; end
        if (t[0] > t[3]) begin s = t[0]; t[0] = t[3]; t[3] = s; end
        if (t[5] > t[8]) begin s = t[5]; t[5] = t[8]; t[8] = s; end
        if (t[4] > t[7]) begin s = t[4]; t[4] = t[7]; t[7] = s; end
        if (t[3] > t[6]) begin s = t[3]; t[3] = t[6]; t[6] = s; end
        if (t[1] > t[4]) begin s = t[1]; t[1] = t[4]; t[4] = s; end
        if (t[2] > t[5]) begin s = t[2]; t[2] = t[5]; t[5] = s; end
        if (t[4] > t[7]) begin s = t[4]; t[4] = t[7]; t[7] = s; end
        if (t[4] > t[2]) begin s = t[4]; t[4] = t[2]; t[2] = s; end
        if (t[6] > t[4]) begin s = t[6]; t[6] = t[4]; t[4] = s; end
        if (t[4] > t[2]) begin s = t[4]; t[4] = t[2]; t[2] = s; end
        return t[MID_RANK];
    endfunction

endpackage

>>> src/rmn_window.sv
// Input stage: pixel window, row and column counters and the tap register.
module rmn_window #(
    parameter int MAX_ROWS = 1080,
    parameter int MAX_COLS = 1920
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rmn_pkg::t_dims i_dims,
    input  logic           i_valid,
    output logic           o_ready,
    input  rmn_pkg::t_pix  i_pixel,
    output logic           o_valid,
    input  logic           i_ready,
    output rmn_pkg::t_taps o_taps
);
    import rmn_pkg::*;

    localparam logic [DIM_W:0] L_MAX_ROWS = (DIM_W+1)'(MAX_ROWS);
    localparam logic [DIM_W:0] L_MAX_COLS = (DIM_W+1)'(MAX_COLS);

    t_pix           r_window [TAPS-1];
    t_dim           r_col;
    t_dim           r_row;
    logic           r_valid;
    t_taps          r_taps;

    logic [DIM_W:0] rows_eff;
    logic [DIM_W:0] cols_eff;
    logic [DIM_W:0] col_inc;
    logic [DIM_W:0] row_inc;
    logic           row_end;
    logic           frame_end;
    logic           take;
    t_taps          n_taps;

    always_comb begin
        if (i_dims.rows == '0) begin
            rows_eff = (DIM_W+1)'(1);
        end else if ({1'b0, i_dims.rows} > L_MAX_ROWS) begin
            rows_eff = L_MAX_ROWS;
        end else begin
            rows_eff = {1'b0, i_dims.rows};
        end
        if (i_dims.cols == '0) begin
            cols_eff = (DIM_W+1)'(1);
        end else if ({1'b0, i_dims.cols} > L_MAX_COLS) begin
            cols_eff = L_MAX_COLS;
        end else begin
            cols_eff = {1'b0, i_dims.cols};
        end
    end

    assign col_inc   = {1'b0, r_col} + (DIM_W+1)'(1);
    assign row_inc   = {1'b0, r_row} + (DIM_W+1)'(1);
    assign row_end   = (col_inc >= cols_eff);
    assign frame_end = row_end && (row_inc >= rows_eff);

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_taps.taps[0] = i_pixel;
        for (int k = 1; k < TAPS; k++) begin
            n_taps.taps[k] = r_window[k-1];
        end
        n_taps.last = frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS-1; k++) begin
                r_window[k] <= '0;
            end
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                if (frame_end) begin
                    for (int k = 0; k < TAPS-1; k++) begin
                        r_window[k] <= '0;
                    end
                    r_col <= '0;
                    r_row <= '0;
                end else begin
                    for (int k = 0; k < TAPS-1; k++) begin
                        r_window[k] <= n_taps.taps[k];
                    end
                    if (row_end) begin
                        r_col <= '0;
                        r_row <= row_inc[DIM_W-1:0];
                    end else begin
                        r_col <= col_inc[DIM_W-1:0];
                    end
                end
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_taps <= n_taps;
        end
    end

    assign o_valid = r_valid;
    assign o_taps  = r_taps;

endmodule

>>> src/rmn_median.sv
// Output stage: median of the nine taps into the result register.
module rmn_median (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rmn_pkg::t_taps i_taps,
    output logic           o_valid,
    input  logic           i_ready,
    output rmn_pkg::t_pix  o_median,
    output logic           o_last
);
    import rmn_pkg::*;

    logic r_valid;
    t_pix r_median;
    logic r_last;
    logic take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_median <= median9(i_taps.taps);
            r_last   <= i_taps.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_median = r_median;
    assign o_last   = r_last;

endmodule

>>> src/running_median_of_nine.sv
// Top level of the nine-tap running median filter with its register port.
//
//  Channel   | Direction | Signals                              | Word
//  ----------+-----------+--------------------------------------+---------------------------
//  s_axis    | in        | tvalid, tready, tdata[7:0]           | pixel_in
//  m_axis    | out       | tvalid, tready, tdata[7:0], tlast    | median_out, frame_last
//  apb       | in/out    | psel, penable, pwrite, paddr, pwdata | frame_rows @0, frame_cols @4
//
//  One word is accepted per clock while the output keeps taking words; each
//  word gives exactly one result word, through the tap register and then the
//  result register.  The rate is set by the median network between those two
//  registers, which handles one window per cycle.
//  Reset (synchronous, active low) clears the window, both counters and the
//  valid flags, and loads 1080 rows by 1920 columns.
//  A stall on the output holds the result word and backs up one stage at a
//  time; s_axis_tready is high whenever m_axis_tready is high.
module running_median_of_nine #(
    parameter int MAX_ROWS = 1080,
    parameter int MAX_COLS = 1920
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    // Median output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] median_out
    output logic        m_axis_tlast,   // frame_last
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rmn_pkg::*;

    t_dims r_dims;
    logic  cfg_write;
    logic  mid_valid;
    logic  mid_ready;
    t_taps mid_taps;

    // The register port never waits; a write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.rows <= DIM_W'(1080);
            r_dims.cols <= DIM_W'(1920);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_ROWS: r_dims.rows <= pwdata[DIM_W-1:0];
                REG_COLS: r_dims.cols <= pwdata[DIM_W-1:0];
                default:  r_dims      <= r_dims;
            endcase
        end
    end

    // Reads return the raw stored value, not the clamped one.
    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = {{(32-DIM_W){1'b0}}, r_dims.rows};
            REG_COLS: prdata = {{(32-DIM_W){1'b0}}, r_dims.cols};
            default:  prdata = '0;
        endcase
    end

    // First stage: the new pixel joins the eight stored ones, and the
    // counters decide whether this is the final pixel of the frame, in
    // which case the window is cleared behind it.
    rmn_window #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dims  (r_dims),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (s_axis_tdata),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_taps  (mid_taps)
    );

    // Second stage: the sorting network picks the median of the taps.
    rmn_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mid_valid),
        .o_ready  (mid_ready),
        .i_taps   (mid_taps),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_median (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

>>> src/rmn_checker.sv
// Port-level checker for the running median filter, with its bind.
`include "assert_macros.svh"

module rmn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);

    // The register port never inserts wait states.
    `ASSERT_ALWAYS(a_pready_high, i_clk, !i_rst_n, pready)

    // Nothing is offered in the cycle after reset.
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid)

    // A draining output lets the whole pipeline move, so input is taken.
    `ASSERT_IMPL(a_flow_through, i_clk, !i_rst_n, m_axis_tready, s_axis_tready)

    // A stalled result word holds its data and frame mark.
    `ASSERT_NEXT(a_hold_stall, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind running_median_of_nine rmn_checker u_rmn_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the nine-tap running median filter with its register port.
module testbench;
    import rmn_pkg::*;

    // Frame limits handed to the block, and kept by the predictor as well.
    localparam int ROWS_MAX     = 1080;
    localparam int COLS_MAX     = 1920;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 700;
    // The long output hold-off starts once this many results have come back.
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 80;
    // Two register stages between input and output, plus some margin.
    localparam int DRAIN_CYCLES = 4;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [2:0] ADDR_ROWS = {REG_ROWS, 2'b00};
    localparam logic [2:0] ADDR_COLS = {REG_COLS, 2'b00};

    // How the pixel values of one run of words are drawn.
    typedef enum int {
        STYLE_UNIFORM,
        STYLE_EXTREME,
        STYLE_NARROW,
        STYLE_RAMP
    } pix_style_e;

    typedef struct {
        t_pix median;
        logic last;
    } median_word_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] pixel_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] median_out
    logic        m_axis_tlast;         // frame_last
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Pixels waiting to be offered, and medians waiting to come out.
    t_pix         pixel_q [$];
    median_word_t median_q [$];

    // Predictor state: the eight previous pixels (newest first), the
    // position in the frame and the register values as written.
    t_pix history [TAPS-1];
    t_dim col_pos  = '0;
    t_dim row_pos  = '0;
    t_dim rows_cfg = t_dim'(1080);
    t_dim cols_cfg = t_dim'(1920);

    bit calm = 1'b0;        // no random gaps on either side while set
    int send_gap = 0;
    int ready_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int pixels_sent = 0;
    int results_seen = 0;
    int frames_seen = 0;
    int settings_used = 0;
    int mismatches = 0;
    int cycle_count = 0;

    running_median_of_nine #(
        .MAX_ROWS (ROWS_MAX),
        .MAX_COLS (COLS_MAX)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The median is the value that has at most four values below it and
    // at least five values at or below it.
    function automatic t_pix median_by_rank(input t_pix v [TAPS]);
        int   below;
        int   not_above;
        t_pix pick;
        pick = v[0];
        for (int i = 0; i < TAPS; i++) begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < TAPS; j++) begin
                if (v[j] < v[i]) below++;
                if (v[j] <= v[i]) not_above++;
            end
            if (below <= MID_RANK && not_above > MID_RANK) pick = v[i];
        end
        return pick;
    endfunction

    // A count of zero means one; anything above the limit means the limit.
    function automatic int effective_dim(input t_dim raw, input int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    // Works out the median word for one accepted pixel and moves the window
    // and the frame position on.  The last pixel of a frame clears the window.
    task automatic predict_median(input t_pix pix);
        t_pix         taps [TAPS];
        median_word_t rec;
        int           rows;
        int           cols;
        logic         row_end;
        rows    = effective_dim(rows_cfg, ROWS_MAX);
        cols    = effective_dim(cols_cfg, COLS_MAX);
        taps[0] = pix;
        for (int i = 1; i < TAPS; i++) taps[i] = history[i-1];
        row_end    = (int'(col_pos) + 1 >= cols);
        rec.median = median_by_rank(taps);
        rec.last   = row_end && (int'(row_pos) + 1 >= rows);
        median_q.push_back(rec);
        if (rec.last) begin
            for (int i = 0; i < TAPS - 1; i++) history[i] = '0;
            col_pos = '0;
            row_pos = '0;
        end else begin
            for (int i = 0; i < TAPS - 1; i++) history[i] = taps[i];
            if (row_end) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
            end else begin
                col_pos = col_pos + 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Gap lengths: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_pix draw_pixel(input pix_style_e style, input t_pix base, input int k);
        case (style)
            STYLE_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            STYLE_NARROW:  return base + t_pix'($urandom_range(0, 3));
            STYLE_RAMP:    return base + t_pix'(k);
            default:       return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    // Sender: offers the queued pixels one word at a time, with random gaps
    // between words.  The gaps are skipped while the output is held off, so
    // that the block fills up and has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_median(s_axis_tdata);
                pixels_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0 && hold_left == 0) begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_axis_tdata  <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted result word against the oldest
    // prediction and stalls at random.
    always @(posedge i_clk) begin : receiver
        median_word_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_gap     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tlast) frames_seen++;
                if (median_q.size() == 0) begin
                    report_mismatch("result with none expected", int'(m_axis_tdata), -1);
                end else begin
                    want = median_q.pop_front();
                    if (m_axis_tdata !== want.median) begin
                        report_mismatch("median_out", int'(m_axis_tdata), int'(want.median));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch("frame_last", int'(m_axis_tlast), int'(want.last));
                    end
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (ready_gap != 0) begin
                ready_gap     <= ready_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                ready_gap     <= pick_gap();
            end
        end
    end

    // One long hold-off of the output, counted here on its own.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, median_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Register write: a setup cycle, then an access cycle that completes at
    // the edge where pready is seen high.  The upper data bits are random;
    // only the low eleven bits are kept by the block.
    task automatic write_reg(input logic [2:0] addr, input t_dim value);
        logic [31:0] data;
        data        = $urandom();
        data[10:0]  = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_ROWS) rows_cfg = value;
        else cols_cfg = value;
    endtask

    task automatic set_frame(input t_dim rows, input t_dim cols);
        write_reg(ADDR_ROWS, rows);
        write_reg(ADDR_COLS, cols);
        settings_used++;
    endtask

    // Waits until every queued pixel has gone in and every median has come
    // out, then lets the pipeline settle.
    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_axis_tvalid || median_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Queues one run of pixels away from the active edge and sees it through.
    task automatic send_run(input pix_style_e style, input int count, input bit quiet);
        t_pix base;
        base = t_pix'($urandom_range(0, 252));
        @(negedge i_clk);
        calm = quiet;
        for (int k = 0; k < count; k++) pixel_q.push_back(draw_pixel(style, base, k));
        wait_idle();
    endtask

    initial begin : sequencer
        t_pix opening [12];
        int   random_sent;
        int   count;
        int   pick;
        t_dim rows;
        t_dim cols;

        for (int i = 0; i < TAPS - 1; i++) history[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset frame size: full-scale values, runs of the maximum that
        // outweigh the zero padding, and patterns that toggle every bit.
        opening = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE};
        @(negedge i_clk);
        foreach (opening[k]) pixel_q.push_back(opening[k]);
        wait_idle();
        settings_used++;

        // One-pixel frames: every word ends a frame and the window stays empty.
        set_frame(t_dim'(1), t_dim'(1));
        send_run(STYLE_UNIFORM, 3, 1'b0);
        // Zero counts behave as one.
        set_frame(t_dim'(0), t_dim'(0));
        send_run(STYLE_EXTREME, 2, 1'b0);
        // Counts above the limits saturate.
        set_frame(t_dim'(2047), t_dim'(2047));
        send_run(STYLE_UNIFORM, 3, 1'b0);
        // Exact row limit with two columns, set while the column count is already past two, so
        // the current row ends on the next pixel.
        set_frame(t_dim'(1080), t_dim'(2));
        send_run(STYLE_UNIFORM, 3, 1'b1);
        set_frame(t_dim'(1080), t_dim'(1920));

        // Random part: small frames so that many frame ends are reached,
        // with one or both registers rewritten between runs.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            rows = ($urandom_range(0, 9) == 0) ? t_dim'(0) : t_dim'($urandom_range(1, 5));
            cols = ($urandom_range(0, 9) == 0) ? t_dim'(0) : t_dim'($urandom_range(1, 16));
            pick = $urandom_range(0, 3);
            if (pick == 0) write_reg(ADDR_ROWS, rows);
            else if (pick == 1) write_reg(ADDR_COLS, cols);
            else begin
                write_reg(ADDR_ROWS, rows);
                write_reg(ADDR_COLS, cols);
            end
            settings_used++;
            count = $urandom_range(10, 60);
            send_run(pix_style_e'($urandom_range(0, 3)), count, $urandom_range(0, 3) == 0);
            random_sent += count;
        end

        $display("Ran %0d pixels through %0d frame settings; %0d frame ends were seen.",
                 pixels_sent, settings_used, frames_seen);
        $display("The output was held off once for %0d cycles with the input still offering.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
